[rtl/core/maw_pkg.sv]
// shared types, constants and sine table builder for the morphing additive wavetable
package maw_pkg;

    // fixed field widths
    localparam int MORPH_W      = 16;
    localparam int MORPH_INT_W  = 4;
    localparam int MORPH_FRAC_W = 12;
    localparam int SEL_W        = 3;
    localparam int SAMPLE_W     = 16;
    localparam int PART_W       = 16;
    localparam int SPEC_W       = 17;
    localparam int MULT_W       = 8;
    localparam int LANES        = 3;
    localparam int TABLE_LEN    = 12;

    // table select codes
    localparam logic [SEL_W-1:0] SEL_FIB  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_HARM = 3'd2;
    localparam logic [SEL_W-1:0] SEL_SD2  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_SD3  = 3'd4;

    // spectrum families; pure sine runs as fibonacci spectrum 0 with no crossfade
    typedef enum logic [1:0] {
        MODE_FIB,
        MODE_HARM,
        MODE_SD2,
        MODE_SD3
    } t_mode;

    // partial multiples and sign of one spectrum
    typedef struct packed {
        logic [LANES-1:0][MULT_W-1:0] mult;
        logic                         neg;
    } t_spec_cfg;

    // partial tables
    localparam logic [MULT_W-1:0] FIB_BIN [TABLE_LEN] =
        '{8'd1, 8'd2, 8'd2, 8'd3, 8'd5, 8'd8, 8'd13, 8'd21, 8'd34, 8'd55, 8'd89, 8'd144};
    localparam logic [TABLE_LEN-1:0] FIB_NEG = 12'b1001_0010_0110;
    localparam logic [MULT_W-1:0] SD2_A [TABLE_LEN] =
        '{8'd5, 8'd5, 8'd3, 8'd5, 8'd4, 8'd4, 8'd7, 8'd6, 8'd7, 8'd9, 8'd3, 8'd5};
    localparam logic [MULT_W-1:0] SD2_B [TABLE_LEN] =
        '{8'd12, 8'd10, 8'd8, 8'd9, 8'd10, 8'd14, 8'd18, 8'd20, 8'd16, 8'd24, 8'd12, 8'd8};
    localparam logic [MULT_W-1:0] SD3_A [TABLE_LEN] =
        '{8'd5, 8'd7, 8'd7, 8'd11, 8'd14, 8'd13, 8'd17, 8'd16, 8'd7, 8'd10, 8'd18, 8'd12};
    localparam logic [MULT_W-1:0] SD3_B [TABLE_LEN] =
        '{8'd8, 8'd10, 8'd16, 8'd19, 8'd18, 8'd18, 8'd22, 8'd24, 8'd18, 8'd18, 8'd21, 8'd22};

    // sundial mix weights, Q14
    localparam logic signed [31:0] SD2_W0  = 32'sd2458;
    localparam logic signed [31:0] SD2_W12 = 32'sd8192;
    localparam logic signed [31:0] SD3_W0  = 32'sd8192;
    localparam logic signed [31:0] SD3_W12 = 32'sd6062;

    // fixed point constants
    localparam logic [31:0] INV_PI_Q32  = 32'd1367130551;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // first quadrant sine, Q14, from a Q30 quadrant fraction (taylor to x^11)
    function automatic logic [14:0] sine_q14(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] v;
        x   = (r * HALF_PI_Q30) >> 30;
        x2  = (x * x) >> 30;
        acc = ONE_Q30;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd110;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd72;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd42;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd20;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd6;
        acc = (x * acc) >> 30;
        v   = (acc + 64'd32768) >> 16;
        return v[14:0];
    endfunction

    // partial multiples for spectrum k of a family
    function automatic t_spec_cfg spec_setup(input t_mode mode, input logic [MORPH_INT_W-1:0] k);
        logic [MORPH_INT_W-1:0] e;
        logic [MORPH_INT_W:0]   h;
        t_spec_cfg              c;
        e = (k >= MORPH_INT_W'(TABLE_LEN)) ? k - MORPH_INT_W'(TABLE_LEN) : k;
        h = {1'b0, k} + 5'd1;
        c = '0;
        unique case (mode)
            MODE_FIB: begin
                c.mult[0] = FIB_BIN[e];
                c.neg     = FIB_NEG[e];
            end
            MODE_HARM: begin
                c.mult[0] = MULT_W'(h);
                c.mult[1] = MULT_W'(h);
                c.neg     = h[0];
            end
            MODE_SD2: begin
                c.mult[0] = 8'd1;
                c.mult[1] = SD2_A[e];
                c.mult[2] = SD2_B[e];
            end
            MODE_SD3: begin
                c.mult[0] = 8'd1;
                c.mult[1] = SD3_A[e];
                c.mult[2] = SD3_B[e];
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/core/morphing_additive_wavetable_top.sv]
// morphing additive wavetable: six stage sample pipeline
//
// Input channel (i_in_valid / o_in_stall) takes one word per clock while o_in_stall
// is low: a Q0.n wave phase, a Q4.12 morph position and a table select. Output channel
// (o_out_valid / i_out_stall) returns one Q2.14 saturated sample per word, in order.
// The accepting edge loads the first stage. While the output is not stalled, throughput
// is one word per clock through the six register stages:
// spectrum setup, partial phase multiply, quarter-wave sine table lookup, spectrum mix,
// crossfade multiply, round/clamp.
// Each stage has its own valid bit; a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up while the receiver stalls and input is still
// taken until every stage holds a word. o_in_stall rises only when the pipeline is
// full and the output word is stalled.
// Reset (synchronous, active low) clears all valid bits; the payload registers are not reset.
// SINE_ROM_DEPTH must be a power of two; the table keeps only a quarter wave.
module morphing_additive_wavetable_top #(
    parameter int PHASE_FRAC_BITS = 24,
    parameter int SINE_ROM_DEPTH  = 1024,
    parameter int SPECTRUM_COUNT  = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [PHASE_FRAC_BITS-1:0]            i_phase_frac,
    input  logic [maw_pkg::MORPH_W-1:0]           i_morph_pos,
    input  logic [maw_pkg::SEL_W-1:0]             i_table_select,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [maw_pkg::SAMPLE_W-1:0]   o_sample
);
    import maw_pkg::*;

    localparam int PFB    = PHASE_FRAC_BITS;
    localparam int NSTG   = 6;
    localparam int ADDR_W = $clog2(SINE_ROM_DEPTH);
    localparam int QTR    = SINE_ROM_DEPTH / 4;
    localparam int QSH    = 32 - ADDR_W;
    localparam int OFF_SH = 32 - PFB;
    localparam logic [MORPH_W-1:0] MORPH_MAX = MORPH_W'((SPECTRUM_COUNT - 1) << MORPH_FRAC_W);
    // two radians of phase, 2^32/pi rounded to the phase width
    localparam logic [33:0] OFF_WIDE =
        ((34'(INV_PI_Q32) << 1) + (34'd1 << OFF_SH)) >> (OFF_SH + 1);
    localparam logic [PFB-1:0] HARM_OFF = OFF_WIDE[PFB-1:0];

    // quarter-wave sine table, built at elaboration
    logic [14:0] w_qtr [QTR+1];
    for (genvar j = 0; j <= QTR; j++) begin : g_qtr
        localparam logic [14:0] QV = sine_q14(64'(j) << QSH);
        assign w_qtr[j] = QV;
    end

    // pipeline control
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG-1:0] w_rdy;

    // stage registers
    logic [PFB-1:0]                 r_s0_p;
    t_mode                          r_s0_mode;
    logic [MORPH_FRAC_W-1:0]        r_s0_f;
    t_spec_cfg                      r_s0_cfg [2];
    logic [PFB-1:0]                 n_s0_p;
    t_mode                          n_s0_mode;
    logic [MORPH_FRAC_W-1:0]        n_s0_f;
    t_spec_cfg                      n_s0_cfg [2];

    logic [PFB-1:0]                 r_s1_ph [2*LANES];
    t_mode                          r_s1_mode;
    logic [MORPH_FRAC_W-1:0]        r_s1_f;
    logic [1:0]                     r_s1_neg;
    logic [PFB-1:0]                 n_s1_ph [2*LANES];

    logic signed [PART_W-1:0]       r_s2_s [2*LANES];
    t_mode                          r_s2_mode;
    logic [MORPH_FRAC_W-1:0]        r_s2_f;
    logic [1:0]                     r_s2_neg;
    logic signed [PART_W-1:0]       n_s2_s [2*LANES];

    logic signed [SPEC_W-1:0]       r_s3_spec [2];
    logic [MORPH_FRAC_W-1:0]        r_s3_f;
    logic signed [SPEC_W-1:0]       n_s3_spec [2];

    logic signed [31:0]             r_s4_sum;
    logic signed [31:0]             n_s4_sum;

    logic signed [SAMPLE_W-1:0]     r_s5_sample;
    logic signed [SAMPLE_W-1:0]     n_s5_sample;

    // stage ready chain and valid bits
    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        n_v[0] = w_rdy[0] ? i_in_valid : r_v[0];
        for (int k = 1; k < NSTG; k++) begin
            n_v[k] = w_rdy[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_v[NSTG-1];
    assign o_sample    = r_s5_sample;

    // stage 0: decode select, clamp morph, pick neighbouring spectra
    always_comb begin
        logic [MORPH_W-1:0]     morph;
        logic                   use_morph;
        logic [MORPH_INT_W-1:0] ka;
        logic [MORPH_INT_W-1:0] kb;
        logic [MORPH_INT_W:0]   ka_inc;
        morph     = (i_morph_pos > MORPH_MAX) ? MORPH_MAX : i_morph_pos;
        use_morph = 1'b1;
        n_s0_mode = MODE_FIB;
        unique case (i_table_select)
            SEL_FIB:  n_s0_mode = MODE_FIB;
            SEL_HARM: n_s0_mode = MODE_HARM;
            SEL_SD2:  n_s0_mode = MODE_SD2;
            SEL_SD3:  n_s0_mode = MODE_SD3;
            default:  use_morph = 1'b0;
        endcase
        ka     = use_morph ? morph[MORPH_W-1 -: MORPH_INT_W] : '0;
        n_s0_f = use_morph ? morph[MORPH_FRAC_W-1:0] : '0;
        ka_inc = {1'b0, ka} + 5'd1;
        kb     = (ka_inc >= 5'(SPECTRUM_COUNT)) ? '0 : ka_inc[MORPH_INT_W-1:0];
        n_s0_p      = i_phase_frac;
        n_s0_cfg[0] = spec_setup(n_s0_mode, ka);
        n_s0_cfg[1] = spec_setup(n_s0_mode, kb);
    end

    // stage 1: partial phases, harmonic second partial shifted by two radians
    always_comb begin
        logic [PFB+MULT_W-1:0] prod;
        logic [PFB-1:0]        ph;
        for (int sp = 0; sp < 2; sp++) begin
            for (int ln = 0; ln < LANES; ln++) begin
                prod = r_s0_p * r_s0_cfg[sp].mult[ln];
                ph   = prod[PFB-1:0];
                if (ln == 1 && r_s0_mode == MODE_HARM) begin
                    ph = ph + HARM_OFF;
                end
                n_s1_ph[sp*LANES+ln] = ph;
            end
        end
    end

    // stage 2: sine lookup through quarter-wave symmetry
    always_comb begin
        logic [PFB+ADDR_W-1:0] ext;
        logic [ADDR_W-1:0]     idx;
        logic [ADDR_W-2:0]     jj;
        logic signed [PART_W-1:0] sv;
        for (int l = 0; l < 2*LANES; l++) begin
            ext = {r_s1_ph[l], {ADDR_W{1'b0}}};
            idx = ext[PFB+ADDR_W-1 -: ADDR_W];
            jj  = {1'b0, idx[ADDR_W-3:0]};
            if (idx[ADDR_W-2]) begin
                jj = (ADDR_W-1)'(QTR) - jj;
            end
            sv = signed'({1'b0, w_qtr[jj]});
            n_s2_s[l] = idx[ADDR_W-1] ? -sv : sv;
        end
    end

    // stage 3: mix partials into the two spectra
    always_comb begin
        logic signed [31:0] acc;
        logic signed [SPEC_W-1:0] t;
        for (int sp = 0; sp < 2; sp++) begin
            acc = '0;
            t   = '0;
            unique case (r_s2_mode)
                MODE_FIB: begin
                    t = SPEC_W'(r_s2_s[sp*LANES]);
                    t = r_s2_neg[sp] ? -t : t;
                end
                MODE_HARM: begin
                    t = SPEC_W'(r_s2_s[sp*LANES]) + SPEC_W'(r_s2_s[sp*LANES+1]);
                    t = r_s2_neg[sp] ? -t : t;
                end
                MODE_SD2: begin
                    acc = 32'(r_s2_s[sp*LANES]) * SD2_W0
                        + 32'(r_s2_s[sp*LANES+1]) * SD2_W12
                        + 32'(r_s2_s[sp*LANES+2]) * SD2_W12 + 32'sd8192;
                    t = SPEC_W'(acc >>> 14);
                end
                MODE_SD3: begin
                    acc = 32'(r_s2_s[sp*LANES]) * SD3_W0
                        + 32'(r_s2_s[sp*LANES+1]) * SD3_W12
                        + 32'(r_s2_s[sp*LANES+2]) * SD3_W12 + 32'sd8192;
                    t = SPEC_W'(acc >>> 14);
                end
            endcase
            n_s3_spec[sp] = t;
        end
    end

    // stage 4: crossfade products
    always_comb begin
        logic [MORPH_FRAC_W:0] wa;
        wa = 13'd4096 - {1'b0, r_s3_f};
        n_s4_sum = 32'(r_s3_spec[0]) * 32'(signed'({1'b0, wa}))
                 + 32'(r_s3_spec[1]) * 32'(signed'({2'b0, r_s3_f}));
    end

    // stage 5: round and saturate
    always_comb begin
        logic signed [31:0] t;
        t = (r_s4_sum + 32'sd2048) >>> 12;
        if (t > 32'sd32767) begin
            n_s5_sample = 16'sh7fff;
        end else if (t < -32'sd32768) begin
            n_s5_sample = 16'sh8000;
        end else begin
            n_s5_sample = t[SAMPLE_W-1:0];
        end
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_p    <= n_s0_p;
            r_s0_mode <= n_s0_mode;
            r_s0_f    <= n_s0_f;
            r_s0_cfg  <= n_s0_cfg;
        end
        if (w_rdy[1]) begin
            r_s1_ph   <= n_s1_ph;
            r_s1_mode <= r_s0_mode;
            r_s1_f    <= r_s0_f;
            r_s1_neg  <= {r_s0_cfg[1].neg, r_s0_cfg[0].neg};
        end
        if (w_rdy[2]) begin
            r_s2_s    <= n_s2_s;
            r_s2_mode <= r_s1_mode;
            r_s2_f    <= r_s1_f;
            r_s2_neg  <= r_s1_neg;
        end
        if (w_rdy[3]) begin
            r_s3_spec <= n_s3_spec;
            r_s3_f    <= r_s2_f;
        end
        if (w_rdy[4]) begin
            r_s4_sum <= n_s4_sum;
        end
        if (w_rdy[5]) begin
            r_s5_sample <= n_s5_sample;
        end
    end

    // input is held off only when every stage is full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v && i_out_stall))
        else $error("input stalled while the pipeline has room");

    // an accepted word lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v[0])
        else $error("accepted word missing from first stage");

    // a finished word moves to a free output register
    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-2] && (!o_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("word lost before the output register");

    // a full pipeline stays full while its output word is stalled
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && i_out_stall) |=> (r_v == {NSTG{1'b1}}))
        else $error("stage emptied while the output was stalled");

endmodule
